FILE: rtl/lrbts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbts_pkg
// Shared types, codes and defaults of the latest-record-before-time search.
// ----------------------------------------------------------------------------
package lrbts_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int SAT_COUNT_DEF   = 24;

  localparam int TIME_W   = 32;
  localparam int SATNUM_W = 6;
  localparam int LEAP_W   = 6;
  localparam int AGE_W    = 16;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request types
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SAT   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_TOO_OLD   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 2'd1;

  localparam logic [LEAP_W-1:0] LEAP_RESET    = 6'd0;
  localparam logic [AGE_W-1:0]  MAX_AGE_RESET = 16'd1800;

  typedef struct packed {
    logic                req_type;
    logic [SATNUM_W-1:0] sat_number;
    logic [TIME_W-1:0]   time_stamp;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  record_index;
    logic [COUNT_W-1:0]  sat_record_count;
  } rsp_t;

  typedef struct packed {
    logic [LEAP_W-1:0] leap_offset_sec;
    logic [AGE_W-1:0]  max_age_sec;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK
  } state_t;

endpackage

FILE: rtl/latest_record_before_time_search.sv
`timescale 1ns / 1ps
// Append, or request with an invalid satellite: result in the next cycle;
// busy stays low, so a new transaction can start in the next cycle.
// Query: scans stored records newest first, one RAM read per cycle; busy holds
// until the result, which follows the check state after a match, or comes
// straight from the scan when no record matches.
// Synchronous reset empties the store, clears all counts and loads defaults.
// ----------------------------------------------------------------------------
// latest_record_before_time_search
// Append-only record store with a backward search for the latest record.
// ----------------------------------------------------------------------------
module latest_record_before_time_search #(
  parameter int STORE_DEPTH = lrbts_pkg::STORE_DEPTH_DEF,
  parameter int SAT_COUNT   = lrbts_pkg::SAT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  lrbts_pkg::req_t                  req,
  output logic                             result_valid,
  output lrbts_pkg::rsp_t                  result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lrbts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrbts_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int SAT_W = $clog2(SAT_COUNT + 1);
  localparam int REC_W = SAT_W + lrbts_pkg::TIME_W;

  lrbts_pkg::cfg_t             cfg;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [REC_W-1:0]            ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [REC_W-1:0]            ram_rdata;
  logic [SAT_W-1:0]            q_sat;
  logic [lrbts_pkg::TIME_W-1:0] q_time;
  logic                        hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leap_offset_sec <= lrbts_pkg::LEAP_RESET;
      cfg.max_age_sec     <= lrbts_pkg::MAX_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrbts_pkg::CFG_LEAP:    cfg.leap_offset_sec <= cfg_data[lrbts_pkg::LEAP_W-1:0];
        lrbts_pkg::CFG_MAX_AGE: cfg.max_age_sec     <= cfg_data[lrbts_pkg::AGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrbts_ram #(
    .WIDTH (REC_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lrbts_match #(
    .SAT_W (SAT_W)
  ) u_match (
    .rec_sat  (ram_rdata[REC_W-1:lrbts_pkg::TIME_W]),
    .rec_time (ram_rdata[lrbts_pkg::TIME_W-1:0]),
    .q_sat    (q_sat),
    .q_time   (q_time),
    .leap     (cfg.leap_offset_sec),
    .hit      (hit)
  );

  lrbts_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAT_COUNT   (SAT_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .q_sat_o      (q_sat),
    .q_time_o     (q_time),
    .hit          (hit)
  );

endmodule

FILE: rtl/lrbts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbts_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lrbts_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lrbts_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbts_match
// Compare unit: one stored record against the query, once per scan cycle.
// ----------------------------------------------------------------------------
module lrbts_match #(
  parameter int SAT_W = 5
) (
  input  logic [SAT_W-1:0]             rec_sat,
  input  logic [lrbts_pkg::TIME_W-1:0] rec_time,
  input  logic [SAT_W-1:0]             q_sat,
  input  logic [lrbts_pkg::TIME_W-1:0] q_time,
  input  logic [lrbts_pkg::LEAP_W-1:0] leap,
  output logic                         hit
);

  logic [lrbts_pkg::TIME_W:0] shifted;

  // one extra bit so the leap offset never wraps the record time
  assign shifted = {1'b0, rec_time} + {{(lrbts_pkg::TIME_W + 1 - lrbts_pkg::LEAP_W){1'b0}}, leap};
  assign hit     = (rec_sat == q_sat) && (shifted <= {1'b0, q_time});

endmodule

FILE: rtl/lrbts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbts_ctrl
// Sequencer: appends, per-satellite counts and the backward scan of the store.
// ----------------------------------------------------------------------------
module lrbts_ctrl #(
  parameter int STORE_DEPTH = lrbts_pkg::STORE_DEPTH_DEF,
  parameter int SAT_COUNT   = lrbts_pkg::SAT_COUNT_DEF,
  localparam int AW    = $clog2(STORE_DEPTH),
  localparam int FW    = $clog2(STORE_DEPTH + 1),
  localparam int SAT_W = $clog2(SAT_COUNT + 1),
  localparam int REC_W = SAT_W + lrbts_pkg::TIME_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lrbts_pkg::req_t              req,
  output logic                         busy,
  input  lrbts_pkg::cfg_t              cfg,
  output logic                         result_valid,
  output lrbts_pkg::rsp_t              result,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [REC_W-1:0]             ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [REC_W-1:0]             ram_rdata,
  output logic [SAT_W-1:0]             q_sat_o,
  output logic [lrbts_pkg::TIME_W-1:0] q_time_o,
  input  logic                         hit
);

  localparam int SLW  = (SAT_COUNT > 1) ? $clog2(SAT_COUNT) : 1;
  localparam int FX_W = (FW > lrbts_pkg::INDEX_W) ? FW : lrbts_pkg::INDEX_W;
  localparam int AX_W = (AW > lrbts_pkg::INDEX_W) ? AW : lrbts_pkg::INDEX_W;
  localparam int TW   = lrbts_pkg::TIME_W;

  lrbts_pkg::state_t state, state_next;

  logic [SAT_W-1:0]              q_sat, q_sat_next;
  logic [SLW-1:0]                q_slot, q_slot_next;
  logic [TW-1:0]                 q_time, q_time_next;
  logic [FW-1:0]                 ptr, ptr_next;
  logic                          pend, pend_next;
  logic [AW-1:0]                 pend_idx, pend_idx_next;
  logic [AW-1:0]                 found_idx, found_idx_next;
  logic [TW-1:0]                 found_time, found_time_next;
  logic [FW-1:0]                 fill_count, fill_count_next;
  logic [lrbts_pkg::COUNT_W-1:0] per_sat [SAT_COUNT];
  logic [lrbts_pkg::COUNT_W-1:0] per_sat_next [SAT_COUNT];
  logic                          result_valid_next;
  lrbts_pkg::rsp_t               result_next;

  logic                          accept;
  logic                          sat_ok;
  logic [SLW-1:0]                slot;
  logic [lrbts_pkg::COUNT_W-1:0] slot_count;
  logic [lrbts_pkg::COUNT_W-1:0] q_count;
  logic [FX_W-1:0]               fill_ext;
  logic [AX_W-1:0]               found_ext;
  logic [TW-1:0]                 age;

  assign busy     = (state != lrbts_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign q_sat_o  = q_sat;
  assign q_time_o = q_time;

  assign sat_ok = (req.sat_number != '0) &&
                  (req.sat_number <= lrbts_pkg::SATNUM_W'(SAT_COUNT));
  assign slot       = SLW'(req.sat_number - lrbts_pkg::SATNUM_W'(1));
  assign slot_count = per_sat[slot];
  assign q_count    = per_sat[q_slot];
  assign fill_ext   = FX_W'(fill_count);
  assign found_ext  = AX_W'(found_idx);
  assign age        = q_time - found_time;

  assign ram_waddr = AW'(fill_count);
  assign ram_wdata = {SAT_W'(req.sat_number), req.time_stamp};
  assign ram_raddr = AW'(ptr - FW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lrbts_pkg::S_IDLE;
      fill_count   <= '0;
      result_valid <= 1'b0;
      pend         <= 1'b0;
      for (int i = 0; i < SAT_COUNT; i++) begin
        per_sat[i] <= '0;
      end
    end else begin
      state        <= state_next;
      fill_count   <= fill_count_next;
      result_valid <= result_valid_next;
      pend         <= pend_next;
      per_sat      <= per_sat_next;
    end
    q_sat      <= q_sat_next;
    q_slot     <= q_slot_next;
    q_time     <= q_time_next;
    ptr        <= ptr_next;
    pend_idx   <= pend_idx_next;
    found_idx  <= found_idx_next;
    found_time <= found_time_next;
    result     <= result_next;
  end

  always_comb begin
    state_next        = state;
    q_sat_next        = q_sat;
    q_slot_next       = q_slot;
    q_time_next       = q_time;
    ptr_next          = ptr;
    pend_next         = pend;
    pend_idx_next     = pend_idx;
    found_idx_next    = found_idx;
    found_time_next   = found_time;
    fill_count_next   = fill_count;
    per_sat_next      = per_sat;
    result_valid_next = 1'b0;
    result_next       = result;
    ram_we            = 1'b0;

    case (state)
      lrbts_pkg::S_IDLE: begin
        if (accept) begin
          if (!sat_ok) begin
            result_valid_next = 1'b1;
            result_next = '{lrbts_pkg::STAT_BAD_SAT, '0, '0};
          end else if (req.req_type == lrbts_pkg::REQ_APPEND) begin
            result_valid_next = 1'b1;
            if (fill_count == FW'(STORE_DEPTH)) begin
              result_next = '{lrbts_pkg::STAT_FULL, '0, slot_count};
            end else begin
              ram_we             = 1'b1;
              fill_count_next    = fill_count + FW'(1);
              per_sat_next[slot] = slot_count + lrbts_pkg::COUNT_W'(1);
              result_next = '{lrbts_pkg::STAT_OK, fill_ext[lrbts_pkg::INDEX_W-1:0],
                              slot_count + lrbts_pkg::COUNT_W'(1)};
            end
          end else begin
            q_sat_next  = SAT_W'(req.sat_number);
            q_slot_next = slot;
            q_time_next = req.time_stamp;
            ptr_next    = fill_count;
            pend_next   = 1'b0;
            state_next  = lrbts_pkg::S_SCAN;
          end
        end
      end

      lrbts_pkg::S_SCAN: begin
        if (pend && hit) begin
          // newest match found; drop the read still in flight
          found_idx_next  = pend_idx;
          found_time_next = ram_rdata[TW-1:0];
          pend_next       = 1'b0;
          state_next      = lrbts_pkg::S_CHECK;
        end else if (!pend && (ptr == '0)) begin
          result_valid_next = 1'b1;
          result_next = '{lrbts_pkg::STAT_NOT_FOUND, '0, q_count};
          state_next  = lrbts_pkg::S_IDLE;
        end else if (ptr != '0) begin
          // issue the next older entry
          pend_next     = 1'b1;
          pend_idx_next = ram_raddr;
          ptr_next      = ptr - FW'(1);
        end else begin
          pend_next = 1'b0;
        end
      end

      lrbts_pkg::S_CHECK: begin
        result_valid_next = 1'b1;
        if (age > TW'(cfg.max_age_sec)) begin
          result_next = '{lrbts_pkg::STAT_TOO_OLD, '0, q_count};
        end else begin
          result_next = '{lrbts_pkg::STAT_OK, found_ext[lrbts_pkg::INDEX_W-1:0], q_count};
        end
        state_next = lrbts_pkg::S_IDLE;
      end

      default: begin
        state_next = lrbts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lrbts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbts_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module lrbts_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            result_valid,
  input lrbts_pkg::rsp_t result
);

  // every accepted transaction either answers at once or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_valid || busy))
    else $error("accepted transaction neither answered nor busy");

  // end of a query always delivers its result
  a_busy_end_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> result_valid)
    else $error("busy dropped without a result");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != lrbts_pkg::STAT_OK)) |-> (result.record_index == '0))
    else $error("nonzero index on a failed transaction");

  a_bad_sat_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == lrbts_pkg::STAT_BAD_SAT))
      |-> (result.sat_record_count == '0))
    else $error("nonzero count for an invalid satellite");

endmodule

bind latest_record_before_time_search lrbts_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the latest-record-before-time search: a directed
// table of appends, queries and register writes, then random phases under
// changing register settings. Each result is checked against the table's
// pinned value if any, else an in-bench copy of the store and its backward search.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STORE_DEPTH = lrbts_pkg::STORE_DEPTH_DEF;
  localparam int SAT_COUNT   = lrbts_pkg::SAT_COUNT_DEF;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 190;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    bit                               is_cfg;
    logic [lrbts_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [lrbts_pkg::CFG_DATA_W-1:0] reg_data;
    lrbts_pkg::req_t                  item;
    bit                               pinned;
    lrbts_pkg::rsp_t                  want;
  } dir_row_t;

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  lrbts_pkg::req_t                  req;
  logic                             result_valid;
  lrbts_pkg::rsp_t                  result;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lrbts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lrbts_pkg::CFG_DATA_W-1:0] cfg_data;

  // expected value supplied by the directed table for the current transaction
  bit              pin_on;
  lrbts_pkg::rsp_t pin_rsp;

  // bench copy of the block state
  logic [lrbts_pkg::SATNUM_W-1:0] rec_sat  [STORE_DEPTH];
  logic [lrbts_pkg::TIME_W-1:0]   rec_time [STORE_DEPTH];
  int                             fill;
  logic [lrbts_pkg::COUNT_W-1:0]  sat_cnt  [SAT_COUNT];
  logic [lrbts_pkg::LEAP_W-1:0]   leap_sec;
  logic [lrbts_pkg::AGE_W-1:0]    age_limit;

  lrbts_pkg::rsp_t rsp_due[$];
  int              n_fail;
  logic [31:0]     cur_time;

  latest_record_before_time_search #(
    .STORE_DEPTH(STORE_DEPTH),
    .SAT_COUNT  (SAT_COUNT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic lrbts_pkg::rsp_t mk_rsp(logic [lrbts_pkg::STATUS_W-1:0] st,
                                             logic [lrbts_pkg::INDEX_W-1:0] idx,
                                             logic [lrbts_pkg::COUNT_W-1:0] cnt);
    lrbts_pkg::rsp_t r;
    r.status = st;
    r.record_index = idx;
    r.sat_record_count = cnt;
    return r;
  endfunction

  function automatic lrbts_pkg::req_t mk_req(logic rt, logic [lrbts_pkg::SATNUM_W-1:0] sat,
                                             logic [lrbts_pkg::TIME_W-1:0] t);
    lrbts_pkg::req_t r;
    r.req_type = rt;
    r.sat_number = sat;
    r.time_stamp = t;
    return r;
  endfunction

  // Append a record or search backward for the latest one; updates the bench state.
  function automatic lrbts_pkg::rsp_t store_and_search(lrbts_pkg::req_t r);
    int slot;
    int k;
    if (r.sat_number < 1 || r.sat_number > SAT_COUNT)
      return mk_rsp(lrbts_pkg::STAT_BAD_SAT, '0, '0);
    slot = int'(r.sat_number) - 1;
    if (r.req_type == lrbts_pkg::REQ_APPEND) begin
      if (fill >= STORE_DEPTH)
        return mk_rsp(lrbts_pkg::STAT_FULL, '0, sat_cnt[slot]);
      rec_sat[fill] = r.sat_number;
      rec_time[fill] = r.time_stamp;
      sat_cnt[slot] = sat_cnt[slot] + 1'b1;
      fill++;
      return mk_rsp(lrbts_pkg::STAT_OK, lrbts_pkg::INDEX_W'(fill - 1), sat_cnt[slot]);
    end
    for (k = fill - 1; k >= 0; k--) begin
      if (rec_sat[k] == r.sat_number &&
          ({1'b0, rec_time[k]} + 33'(leap_sec)) <= {1'b0, r.time_stamp}) begin
        if (32'(r.time_stamp - rec_time[k]) > 32'(age_limit))
          return mk_rsp(lrbts_pkg::STAT_TOO_OLD, '0, sat_cnt[slot]);
        return mk_rsp(lrbts_pkg::STAT_OK, lrbts_pkg::INDEX_W'(k), sat_cnt[slot]);
      end
    end
    return mk_rsp(lrbts_pkg::STAT_NOT_FOUND, '0, sat_cnt[slot]);
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Check results against the oldest expectation, then predict new transactions.
  always @(posedge clk) begin : mon
    lrbts_pkg::rsp_t want;
    if (!rst) begin
      if (result_valid === 1'b1) begin
        if (rsp_due.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $error("result with no transaction pending: %p", result);
        end else begin
          want = rsp_due.pop_front();
          cmp_field("status", 32'(want.status), 32'(result.status));
          cmp_field("record_index", 32'(want.record_index), 32'(result.record_index));
          cmp_field("sat_record_count", 32'(want.sat_record_count),
                    32'(result.sat_record_count));
        end
      end else if (result_valid !== 1'b0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $error("result_valid unknown");
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = store_and_search(req);
        rsp_due = {rsp_due, (pin_on ? pin_rsp : want)};
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          lrbts_pkg::CFG_LEAP:    leap_sec = cfg_data[lrbts_pkg::LEAP_W-1:0];
          lrbts_pkg::CFG_MAX_AGE: age_limit = cfg_data[lrbts_pkg::AGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int u;
    if (burst)
      return 0;
    u = $urandom_range(0, 99);
    if (u < 55) return 0;
    if (u < 90) return $urandom_range(1, 3);
    if (u < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lrbts_pkg::req_t rand_item();
    lrbts_pkg::req_t r;
    int              u;
    int              v;
    int              k;
    r.req_type = ($urandom_range(0, 99) < 30) ? lrbts_pkg::REQ_APPEND : lrbts_pkg::REQ_QUERY;
    u = $urandom_range(0, 99);
    if (u < 3)
      r.sat_number = '0;
    else if (u < 10)
      r.sat_number = lrbts_pkg::SATNUM_W'($urandom_range(SAT_COUNT + 1, 63));
    else if (u < 55)
      r.sat_number = lrbts_pkg::SATNUM_W'($urandom_range(1, 4));
    else
      r.sat_number = lrbts_pkg::SATNUM_W'($urandom_range(1, SAT_COUNT));
    u = $urandom_range(0, 99);
    if (r.req_type == lrbts_pkg::REQ_APPEND) begin
      if (u < 70) begin
        cur_time = cur_time + $urandom_range(0, 600);
        r.time_stamp = cur_time;
      end else if (u < 90) begin
        r.time_stamp = cur_time - $urandom_range(0, 2000);
      end else if (u < 95) begin
        r.time_stamp = $urandom;
      end else begin
        r.time_stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
    end else if (u < 50 && fill > 0) begin
      // aim at a stored record, around the leap and age boundaries
      k = $urandom_range(0, fill - 1);
      if ($urandom_range(0, 4) != 0)
        r.sat_number = rec_sat[k];
      v = $urandom_range(0, 9);
      if (v == 0)
        r.time_stamp = rec_time[k] + 32'(leap_sec) - $urandom_range(0, 2);
      else if (v == 1)
        r.time_stamp = rec_time[k] + 32'(age_limit) + $urandom_range(0, 1);
      else
        r.time_stamp = rec_time[k] +
                       $urandom_range(0, 32'(age_limit) + 32'(leap_sec) + 32'd64);
    end else if (u < 80) begin
      r.time_stamp = cur_time + $urandom_range(0, 3000) - 32'd1000;
    end else if (u < 92) begin
      r.time_stamp = $urandom;
    end else begin
      r.time_stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is accepted.
  task automatic send(input lrbts_pkg::req_t r, input bit pin, input lrbts_pkg::rsp_t want,
                      input int gap);
    if (cfg_valid === 1'b1)
      cfg_valid <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    req     <= r;
    pin_on  <= pin;
    pin_rsp <= want;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [lrbts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lrbts_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop start and wait for every pending result.
  task automatic quiesce();
    if (start === 1'b1)
      start <= 1'b0;
    while (rsp_due.size() != 0) @(negedge clk);
  endtask

  function automatic dir_row_t row_item(logic rt, logic [lrbts_pkg::SATNUM_W-1:0] sat,
                                        logic [lrbts_pkg::TIME_W-1:0] t, bit pin,
                                        lrbts_pkg::rsp_t want);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_data = '0;
    row.item = mk_req(rt, sat, t);
    row.pinned = pin;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t row_reg(logic [lrbts_pkg::CFG_IDX_W-1:0] idx,
                                       logic [lrbts_pkg::CFG_DATA_W-1:0] d);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = d;
    row.item = '0;
    row.pinned = 1'b0;
    row.want = '0;
    return row;
  endfunction

  initial begin : main
    dir_row_t                         rows[$];
    bit                               burst;
    logic [lrbts_pkg::CFG_DATA_W-1:0] d;
    int                               v;

    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pin_on    = 1'b0;
    pin_rsp   = '0;
    fill      = 0;
    foreach (sat_cnt[i]) sat_cnt[i] = '0;
    leap_sec  = lrbts_pkg::LEAP_RESET;
    age_limit = lrbts_pkg::MAX_AGE_RESET;
    n_fail    = 0;
    cur_time  = $urandom;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty store, invalid satellites, first records at the time extremes
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd0, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_NOT_FOUND, 8'd0, 9'd0))};
    rows = {rows, row_item(lrbts_pkg::REQ_APPEND, 6'd0, 32'd5, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_BAD_SAT, 8'd0, 9'd0))};
    rows = {rows, row_item(lrbts_pkg::REQ_APPEND, 6'd25, 32'd5, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_BAD_SAT, 8'd0, 9'd0))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd63, 32'hFFFF_FFFF, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_BAD_SAT, 8'd0, 9'd0))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd0, 32'd0, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_BAD_SAT, 8'd0, 9'd0))};
    rows = {rows, row_item(lrbts_pkg::REQ_APPEND, 6'd1, 32'd100, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_OK, 8'd0, 9'd1))};
    rows = {rows, row_item(lrbts_pkg::REQ_APPEND, 6'd24, 32'hFFFF_FFFF, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_OK, 8'd1, 9'd1))};
    rows = {rows, row_item(lrbts_pkg::REQ_APPEND, 6'd1, 32'd0, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_OK, 8'd2, 9'd2))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd99, 1'b0, '0)};
    // age exactly at the limit, then one past it
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd1800, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_OK, 8'd2, 9'd2))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd1801, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_TOO_OLD, 8'd0, 9'd2))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd24, 32'hFFFF_FFFF, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_OK, 8'd1, 9'd1))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd2, 32'd1000, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_NOT_FOUND, 8'd0, 9'd0))};
    // largest leap offset: record time plus offset must not wrap
    rows = {rows, row_reg(lrbts_pkg::CFG_LEAP, 16'hFFFF)};
    rows = {rows, row_reg(lrbts_pkg::CFG_MAX_AGE, 16'h0000)};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd24, 32'hFFFF_FFFF, 1'b1,
                           mk_rsp(lrbts_pkg::STAT_NOT_FOUND, 8'd0, 9'd1))};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd62, 1'b0, '0)};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd63, 1'b0, '0)};
    // unused register indexes must be ignored
    rows = {rows, row_reg(lrbts_pkg::CFG_LEAP, 16'hFFC0)};
    rows = {rows, row_reg(2'd2, 16'hFFFF)};
    rows = {rows, row_reg(2'd3, 16'h1234)};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd0, 1'b0, '0)};
    rows = {rows, row_item(lrbts_pkg::REQ_APPEND, 6'd24, 32'd0, 1'b0, '0)};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd24, 32'd0, 1'b0, '0)};
    rows = {rows, row_reg(lrbts_pkg::CFG_MAX_AGE, 16'hFFFF)};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd65535, 1'b0, '0)};
    rows = {rows, row_item(lrbts_pkg::REQ_QUERY, 6'd1, 32'd65636, 1'b0, '0)};
    rows = {rows, row_reg(lrbts_pkg::CFG_MAX_AGE, 16'd1800)};

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        quiesce();
        write_reg(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        send(rows[i].item, rows[i].pinned, rows[i].want, pick_gap(1'b0));
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      quiesce();
      // leap register: upper data bits are don't-care
      v = (ph == 1) ? 1 : (ph == 2) ? 0 : $urandom_range(0, 2);
      d = (v == 0) ? 16'h0000 : (v == 1) ? 16'hFFFF : 16'($urandom);
      write_reg(lrbts_pkg::CFG_LEAP, d);
      v = (ph == 1) ? 1 : (ph == 2) ? 0 : $urandom_range(0, 4);
      case (v)
        0: d = 16'h0000;
        1: d = 16'hFFFF;
        2: d = 16'd1800;
        3: d = 16'($urandom_range(0, 300));
        default: d = 16'($urandom);
      endcase
      write_reg(lrbts_pkg::CFG_MAX_AGE, d);
      if ($urandom_range(0, 9) < 3)
        write_reg(lrbts_pkg::CFG_IDX_W'($urandom_range(2, 3)), 16'($urandom));
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send(rand_item(), 1'b0, '0, pick_gap(burst));
    end

    quiesce();
    if (cfg_valid === 1'b1)
      cfg_valid <= 1'b0;
    // hold for one full scan to catch stray results
    repeat (STORE_DEPTH + 16) @(posedge clk);
    if (rsp_due.size() != 0) begin
      n_fail++;
      $error("%0d expected results never arrived", rsp_due.size());
    end
    if (n_fail == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
